// File: sv/fli_pkg.sv
// Shared types and codes for the flux linkage interpolator.
// No dependencies.
`default_nettype none
package fli_pkg;

    localparam int Q16_FRAC = 16;
    localparam int T_W      = Q16_FRAC + 1;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_LOW    = 2'd1,
        ST_HIGH   = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    // Control part of the search token that walks the cell chain.
    typedef struct packed {
        logic    vld;
        logic    found;
        logic    axis;
        t_status status;
    } t_tok;

endpackage
`default_nettype wire

// File: sv/fli_cell.sv
// One table cell: holds one q and one d breakpoint/flux pair and tests the
// passing search token against the interval ending at its own breakpoint.
// Depends on fli_pkg.
`default_nettype none
module fli_cell #(
    parameter int SW      = 16,
    parameter bit IS_HEAD = 1'b0,
    parameter bit IS_TAIL = 1'b0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr,
    input  wire                 i_wr_axis,
    input  wire  signed [SW-1:0] i_wr_bp,
    input  wire  signed [SW-1:0] i_wr_fx,
    input  fli_pkg::t_tok       i_tok,
    input  wire  signed [SW-1:0] i_x,
    input  wire  signed [SW-1:0] i_prev_bp,
    input  wire  signed [SW-1:0] i_prev_fx,
    input  wire  signed [SW-1:0] i_lo_bp,
    input  wire  signed [SW-1:0] i_lo_fx,
    input  wire  signed [SW-1:0] i_hi_bp,
    input  wire  signed [SW-1:0] i_hi_fx,
    output fli_pkg::t_tok       o_tok,
    output logic signed [SW-1:0] o_x,
    output logic signed [SW-1:0] o_prev_bp,
    output logic signed [SW-1:0] o_prev_fx,
    output logic signed [SW-1:0] o_lo_bp,
    output logic signed [SW-1:0] o_lo_fx,
    output logic signed [SW-1:0] o_hi_bp,
    output logic signed [SW-1:0] o_hi_fx
);
    import fli_pkg::*;

    logic signed [SW-1:0] r_bp_q, r_fx_q, r_bp_d, r_fx_d;
    logic signed [SW-1:0] bp, fx;
    t_tok                 n_tok;
    logic signed [SW-1:0] n_lo_bp, n_lo_fx, n_hi_bp, n_hi_fx;

    always_ff @(posedge i_clk) begin
        if (i_wr && !i_wr_axis) begin
            r_bp_q <= i_wr_bp;
            r_fx_q <= i_wr_fx;
        end
        if (i_wr && i_wr_axis) begin
            r_bp_d <= i_wr_bp;
            r_fx_d <= i_wr_fx;
        end
    end

    assign bp = i_tok.axis ? r_bp_d : r_bp_q;
    assign fx = i_tok.axis ? r_fx_d : r_fx_q;

    always_comb begin
        n_tok   = i_tok;
        n_lo_bp = i_lo_bp;
        n_lo_fx = i_lo_fx;
        n_hi_bp = i_hi_bp;
        n_hi_fx = i_hi_fx;
        if (IS_HEAD) begin
            if (i_x <= bp) begin
                n_tok.found  = 1'b1;
                n_tok.status = ST_LOW;
                n_lo_fx      = fx;
            end
        end else if (!i_tok.found && i_x >= i_prev_bp && i_x <= bp) begin
            n_tok.found  = 1'b1;
            n_tok.status = ST_INTERP;
            n_lo_bp      = i_prev_bp;
            n_lo_fx      = i_prev_fx;
            n_hi_bp      = bp;
            n_hi_fx      = fx;
        end
        // high clamp outranks any interval found earlier
        if (IS_TAIL && i_tok.status != ST_LOW && i_x >= bp) begin
            n_tok.found  = 1'b1;
            n_tok.status = ST_HIGH;
            n_lo_fx      = fx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok.vld <= 1'b0;
        end else begin
            o_tok.vld <= i_tok.vld;
        end
        o_tok.found  <= n_tok.found;
        o_tok.axis   <= n_tok.axis;
        o_tok.status <= n_tok.status;
        o_x          <= i_x;
        o_prev_bp    <= bp;
        o_prev_fx    <= fx;
        o_lo_bp      <= n_lo_bp;
        o_lo_fx      <= n_lo_fx;
        o_hi_bp      <= n_hi_bp;
        o_hi_fx      <= n_hi_fx;
    end

endmodule
`default_nettype wire

// File: sv/fli_divider.sv
// Restoring divider for the Q16 interpolation fraction, one bit a cycle.
// Requires numerator below denominator. Depends on fli_pkg.
`default_nettype none
module fli_divider #(
    parameter int SW = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  [SW:0]              i_num,
    input  wire  [SW:0]              i_den,
    output logic                     o_done,
    output logic [fli_pkg::T_W-1:0]  o_quot
);
    import fli_pkg::*;

    localparam int CW = $clog2(Q16_FRAC + 1);

    logic [SW:0]         r_rem, r_den;
    logic [Q16_FRAC-1:0] r_quot;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [SW+1:0]       sh;
    logic                ge;

    assign sh = {r_rem, 1'b0};
    assign ge = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(Q16_FRAC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? (sh[SW:0] - r_den) : sh[SW:0];
            r_quot <= {r_quot[Q16_FRAC-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = {1'b0, r_quot};

endmodule
`default_nettype wire

// File: sv/flux_linkage_interpolator_unit.sv
// Flux linkage interpolator: top level with the cell chain and sequencer.
// Depends on fli_pkg, fli_cell and fli_divider.
//
// Input channel (i_valid / o_stall): a transaction with i_mode = 1 writes
// breakpoint i_current and flux i_flux_entry into entry i_entry_index of
// the table picked by i_axis and gives no result. An index at or above
// TABLE_ENTRIES is dropped. A transaction with i_mode = 0 looks i_current
// up and gives one result transaction.
// Output channel (o_valid / i_stall): o_flux and o_range_status
// (0 interpolated, 1 clamped low, 2 clamped high, 3 no interval).
// A lookup walks a token down TABLE_ENTRIES cells, one per cycle, each
// holding one entry; the first bracketing interval is caught on the way.
// A clamp or flat interval then goes from set-up straight to the output;
// a true interpolation takes a set-up step, the bit-serial divider (skipped
// when the sample sits on the upper breakpoint), a multiply and a final add.
// One lookup is in flight at a time, so o_stall stays high from acceptance
// until the result is taken.
// While i_stall is high the result holds and no new transaction enters.
// Reset empties the sequencer; table contents are undefined until written.
`default_nettype none
module flux_linkage_interpolator_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire                           i_mode,
    input  wire                           i_axis,
    input  wire  [3:0]                    i_entry_index,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_current,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_flux_entry,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_flux,
    output logic [1:0]                    o_range_status
);
    import fli_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int N  = TABLE_ENTRIES;
    localparam int PW = SW + T_W + 2;

    t_state r_state, n_state;

    logic accept, wr_acc, lk_acc;
    assign accept = i_valid && !o_stall;
    assign wr_acc = accept && i_mode;
    assign lk_acc = accept && !i_mode;

    // token chain
    t_tok                 tok [0:N];
    logic signed [SW-1:0] cx  [0:N];
    logic signed [SW-1:0] cpb [0:N];
    logic signed [SW-1:0] cpf [0:N];
    logic signed [SW-1:0] clb [0:N];
    logic signed [SW-1:0] clf [0:N];
    logic signed [SW-1:0] chb [0:N];
    logic signed [SW-1:0] chf [0:N];

    assign tok[0].vld    = lk_acc;
    assign tok[0].found  = 1'b0;
    assign tok[0].axis   = i_axis;
    assign tok[0].status = ST_NONE;
    assign cx[0]  = i_current;
    assign cpb[0] = '0;
    assign cpf[0] = '0;
    assign clb[0] = '0;
    assign clf[0] = '0;
    assign chb[0] = '0;
    assign chf[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        fli_cell #(
            .SW      (SW),
            .IS_HEAD (k == 0),
            .IS_TAIL (k == N - 1)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (wr_acc && (32'(i_entry_index) == k)),
            .i_wr_axis (i_axis),
            .i_wr_bp   (i_current),
            .i_wr_fx   (i_flux_entry),
            .i_tok     (tok[k]),
            .i_x       (cx[k]),
            .i_prev_bp (cpb[k]),
            .i_prev_fx (cpf[k]),
            .i_lo_bp   (clb[k]),
            .i_lo_fx   (clf[k]),
            .i_hi_bp   (chb[k]),
            .i_hi_fx   (chf[k]),
            .o_tok     (tok[k+1]),
            .o_x       (cx[k+1]),
            .o_prev_bp (cpb[k+1]),
            .o_prev_fx (cpf[k+1]),
            .o_lo_bp   (clb[k+1]),
            .o_lo_fx   (clf[k+1]),
            .o_hi_bp   (chb[k+1]),
            .o_hi_fx   (chf[k+1])
        );
    end

    // captured search result
    t_status              r_stat;
    logic signed [SW-1:0] r_x, r_lo_bp, r_lo_fx, r_hi_bp, r_hi_fx;
    logic signed [SW:0]   span, offs, diff;
    logic signed [SW:0]   r_diff;
    logic [T_W-1:0]       r_t;
    logic signed [PW-1:0] r_prod, prod, adj, delta;
    logic signed [SW-1:0] r_flux;

    assign span = {r_hi_bp[SW-1], r_hi_bp} - {r_lo_bp[SW-1], r_lo_bp};
    assign offs = {r_x[SW-1], r_x} - {r_lo_bp[SW-1], r_lo_bp};
    assign diff = {r_hi_fx[SW-1], r_hi_fx} - {r_lo_fx[SW-1], r_lo_fx};

    logic           div_start, div_done;
    logic [T_W-1:0] div_quot;
    logic           direct, full;

    // clamp, miss or flat interval: no arithmetic needed
    assign direct    = (r_stat != ST_INTERP) || (span == '0);
    assign full      = offs == span;
    assign div_start = (r_state == S_SETUP) && !direct && !full;

    fli_divider #(.SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (offs),
        .i_den   (span),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign prod  = PW'($signed({1'b0, r_t})) * PW'(r_diff);
    // truncate toward zero on the Q16 shift
    assign adj   = r_prod[PW-1] ? (r_prod + PW'((1 << Q16_FRAC) - 1)) : r_prod;
    assign delta = adj >>> Q16_FRAC;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (lk_acc) n_state = S_SEARCH;
            S_SEARCH: if (tok[N].vld) n_state = S_SETUP;
            S_SETUP: begin
                if (direct)    n_state = S_OUT;
                else if (full) n_state = S_MUL;
                else           n_state = S_DIV;
            end
            S_DIV:    if (div_done) n_state = S_MUL;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_OUT;
            S_OUT:    if (!i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_OUT:   o_valid = 1'b1;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_SEARCH && tok[N].vld) begin
            r_stat  <= tok[N].found ? tok[N].status : ST_NONE;
            r_x     <= cx[N];
            r_lo_bp <= clb[N];
            r_lo_fx <= clf[N];
            r_hi_bp <= chb[N];
            r_hi_fx <= chf[N];
        end
        if (r_state == S_SETUP) begin
            r_diff <= diff;
            r_t    <= T_W'(1 << Q16_FRAC);
            if (direct) r_flux <= (r_stat == ST_NONE) ? '0 : r_lo_fx;
        end
        if (r_state == S_DIV && div_done) r_t <= div_quot;
        if (r_state == S_MUL) r_prod <= prod;
        if (r_state == S_ADD) r_flux <= r_lo_fx + delta[SW-1:0];
    end

    assign o_flux         = r_flux;
    assign o_range_status = r_stat;

`ifndef SYNTH
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[N].vld |-> r_state == S_SEARCH)
        else $error("search token left the chain outside a search");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_status == ST_NONE) |-> o_flux == '0)
        else $error("missed interval without zero flux");
`endif

endmodule
`default_nettype wire
